// File: hdl/tpkd_pkg.sv
// Shared types, constants and helpers of the TCP payload keyword detector.
`default_nettype none

package tpkd_pkg;

    localparam int BYTE_W       = 8;
    localparam int LINK_W       = 7;
    localparam int KEYWORD_W    = 32;
    localparam int POS_W        = 16;
    localparam int CMP_W        = POS_W + 1;
    localparam int OFS_W        = 9;
    localparam int RESULT_W     = 98;
    localparam int OUT_TDATA_W  = 104;

    // Register reset values: 14-byte link header and the keyword "Flag"
    localparam logic [LINK_W-1:0]    LINK_HEADER_RESET = 7'd14;
    localparam logic [KEYWORD_W-1:0] KEYWORD_RESET     = 32'h466C_6167;

    // Register indexes on the configuration channel
    localparam logic CFG_LINK_HEADER = 1'b0;
    localparam logic CFG_KEYWORD     = 1'b1;

    // Smallest TCP data offset in 32-bit words
    localparam logic [3:0] TCP_MIN_WORDS = 4'd5;

    typedef struct packed {
        logic        keyword_found;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        truncated;
    } result_t;

    // Keyword length: count of bytes before the first zero byte, 0 to 4
    function automatic logic [2:0] keyword_length(input logic [KEYWORD_W-1:0] kw);
        logic [2:0] n;
        logic       stop;
        n    = 3'd0;
        stop = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (!stop && kw[31-8*i -: 8] != 8'h00) begin
                n = n + 3'd1;
            end else begin
                stop = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tcp_payload_keyword_detector_core.sv
// Top level of the TCP payload keyword detector: stream ports, registers, result stage.
`default_nettype none

// Takes a captured frame one byte per beat and gives one result beat per frame,
// on the frame's last byte. A byte can enter every cycle: each byte passes from an
// input register through header-offset compares and a 4-byte window compare into
// the frame state, so the rate is one byte per clock, except that a waiting result
// stalls the next frame's last byte, not the bytes before it.
// The link header length and the keyword are written through the configuration
// channel (index 0 and 1); the user must do so only between frames, as the block
// does not enforce it. The keyword ends at its first zero byte.
module tcp_payload_keyword_detector_core
    import tpkd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [BYTE_W-1:0]      s_tdata,   // [7:0] frame_byte
    input  wire logic                   s_tlast,   // last_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [0] keyword_found, [32:1] source_address,
                                                   // [64:33] dest_address, [80:65] source_port,
                                                   // [96:81] dest_port, [97] truncated
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_index,
    input  wire logic [KEYWORD_W-1:0]   cfg_data
);

    logic                  in_valid_reg;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic                  in_last_reg;
    logic                  out_valid_reg;
    result_t               out_result_reg;
    logic [LINK_W-1:0]     link_reg;
    logic [KEYWORD_W-1:0]  keyword_reg;
    logic                  advance;
    result_t               result;

    // A byte advances unless it closes a frame while the result stage is blocked
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(OUT_TDATA_W - RESULT_W)'(0),
                        out_result_reg.truncated,
                        out_result_reg.dest_port,
                        out_result_reg.source_port,
                        out_result_reg.dest_address,
                        out_result_reg.source_address,
                        out_result_reg.keyword_found};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            link_reg    <= LINK_HEADER_RESET;
            keyword_reg <= KEYWORD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LINK_HEADER: link_reg    <= cfg_data[LINK_W-1:0];
                CFG_KEYWORD:     keyword_reg <= cfg_data;
                default:         link_reg    <= link_reg;
            endcase
        end
    end

    // Input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tpkd_frame_engine u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .frame_byte        (in_byte_reg),
        .last_byte         (in_last_reg),
        .link_header_bytes (link_reg),
        .search_keyword    (keyword_reg),
        .result            (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg) begin
            out_result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tpkd_frame_engine.sv
// Per-byte header parser and payload keyword matcher with its frame state.
`default_nettype none

module tpkd_frame_engine
    import tpkd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [BYTE_W-1:0]    frame_byte,
    input  wire logic                 last_byte,
    input  wire logic [LINK_W-1:0]    link_header_bytes,
    input  wire logic [KEYWORD_W-1:0] search_keyword,
    output result_t                   result
);

    logic [POS_W-1:0]  byte_position_reg, byte_position_next;
    logic [3:0]        ip_words_reg, ip_words_next;
    logic [3:0]        tcp_words_reg, tcp_words_next;
    logic [31:0]       src_addr_reg, src_addr_next;
    logic [31:0]       dst_addr_reg, dst_addr_next;
    logic [15:0]       src_port_reg, src_port_next;
    logic [15:0]       dst_port_reg, dst_port_next;
    logic [23:0]       window_reg, window_next;
    logic [1:0]        fill_reg, fill_next;
    logic              matched_reg, matched_next;
    logic              zero_seen_reg, zero_seen_next;

    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  link_ofs;
    logic [CMP_W-1:0]  tcp_ofs;
    logic [CMP_W-1:0]  pay_ofs;
    logic [OFS_W-1:0]  tcp_start;
    logic [OFS_W-1:0]  pay_start;
    logic [3:0]        data_off;
    logic [2:0]        kw_len;
    logic [31:0]       cand;
    logic              cand_hit;
    logic              in_payload;
    logic              truncated;

    // Header field offsets for this byte
    always_comb
    begin
        pos       = {1'b0, byte_position_reg};
        link_ofs  = CMP_W'(link_header_bytes);
        ip_words_next = (pos == link_ofs) ? frame_byte[3:0] : ip_words_reg;
        tcp_start = OFS_W'(link_header_bytes) + OFS_W'({ip_words_next, 2'b00});
        tcp_ofs   = CMP_W'(tcp_start);
        tcp_words_next = (pos == tcp_ofs + CMP_W'(12)) ? frame_byte[7:4] : tcp_words_reg;
        data_off  = (tcp_words_next < TCP_MIN_WORDS) ? TCP_MIN_WORDS : tcp_words_next;
        pay_start = tcp_start + OFS_W'({data_off, 2'b00});
        pay_ofs   = CMP_W'(pay_start);
    end

    // Address and port capture
    always_comb
    begin
        src_addr_next = src_addr_reg;
        dst_addr_next = dst_addr_reg;
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;
        if (pos >= link_ofs + CMP_W'(12) && pos <= link_ofs + CMP_W'(15)) begin
            src_addr_next = {src_addr_reg[23:0], frame_byte};
        end
        if (pos >= link_ofs + CMP_W'(16) && pos <= link_ofs + CMP_W'(19)) begin
            dst_addr_next = {dst_addr_reg[23:0], frame_byte};
        end
        if (pos == tcp_ofs || pos == tcp_ofs + CMP_W'(1)) begin
            src_port_next = {src_port_reg[7:0], frame_byte};
        end
        if (pos == tcp_ofs + CMP_W'(2) || pos == tcp_ofs + CMP_W'(3)) begin
            dst_port_next = {dst_port_reg[7:0], frame_byte};
        end
    end

    // Keyword compare against the last bytes of the payload window
    always_comb
    begin
        kw_len = keyword_length(search_keyword);
        cand   = {window_reg, frame_byte};
        case (kw_len)
            3'd1:    cand_hit = (cand[7:0]  == search_keyword[31:24]);
            3'd2:    cand_hit = (cand[15:0] == search_keyword[31:16]) && (fill_reg >= 2'd1);
            3'd3:    cand_hit = (cand[23:0] == search_keyword[31:8])  && (fill_reg >= 2'd2);
            3'd4:    cand_hit = (cand       == search_keyword)        && (fill_reg == 2'd3);
            default: cand_hit = 1'b0;
        endcase
    end

    // Payload window and match state
    always_comb
    begin
        in_payload     = (pos >= pay_ofs) && !zero_seen_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        matched_next   = matched_reg;
        zero_seen_next = zero_seen_reg;
        if (in_payload) begin
            if (frame_byte == 8'h00) begin
                zero_seen_next = 1'b1;
            end else begin
                if (cand_hit) begin
                    matched_next = 1'b1;
                end
                window_next = cand[23:0];
                if (fill_reg != 2'd3) begin
                    fill_next = fill_reg + 2'd1;
                end
            end
        end
        byte_position_next = (byte_position_reg == {POS_W{1'b1}}) ?
                             byte_position_reg : byte_position_reg + POS_W'(1);
    end

    // Result of a frame that ends on this byte
    always_comb
    begin
        truncated             = (pos + CMP_W'(1)) < pay_ofs;
        result.truncated      = truncated;
        result.keyword_found  = !truncated && (matched_next || kw_len == 3'd0);
        result.source_address = src_addr_next;
        result.dest_address   = dst_addr_next;
        result.source_port    = src_port_next;
        result.dest_port      = dst_port_next;
    end

    // Frame state: cleared after the last byte of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_position_reg <= '0;
            ip_words_reg      <= '0;
            tcp_words_reg     <= '0;
            src_addr_reg      <= '0;
            dst_addr_reg      <= '0;
            src_port_reg      <= '0;
            dst_port_reg      <= '0;
            window_reg        <= '0;
            fill_reg          <= '0;
            matched_reg       <= 1'b0;
            zero_seen_reg     <= 1'b0;
        end else if (step) begin
            if (last_byte) begin
                byte_position_reg <= '0;
                ip_words_reg      <= '0;
                tcp_words_reg     <= '0;
                src_addr_reg      <= '0;
                dst_addr_reg      <= '0;
                src_port_reg      <= '0;
                dst_port_reg      <= '0;
                window_reg        <= '0;
                fill_reg          <= '0;
                matched_reg       <= 1'b0;
                zero_seen_reg     <= 1'b0;
            end else begin
                byte_position_reg <= byte_position_next;
                ip_words_reg      <= ip_words_next;
                tcp_words_reg     <= tcp_words_next;
                src_addr_reg      <= src_addr_next;
                dst_addr_reg      <= dst_addr_next;
                src_port_reg      <= src_port_next;
                dst_port_reg      <= dst_port_next;
                window_reg        <= window_next;
                fill_reg          <= fill_next;
                matched_reg       <= matched_next;
                zero_seen_reg     <= zero_seen_next;
            end
        end
    end

endmodule

`default_nettype wire
